// ===== rtl/core/fpr_crc8_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants, types and the CRC-8/MAXIM byte update for the framed packet receiver.
package fpr_crc8_pkg;

    // Configuration register defaults and indexes
    localparam logic [7:0] HEADER_RESET = 8'hA5;
    localparam logic [7:0] CRC_POLY_REFL = 8'h8C;
    localparam int         CFG_ADDR_W = 3;
    localparam logic       REG_HEADER = 1'b0;

    // Frame phase, one-hot
    typedef enum logic [10:0] {
        PH_WAIT = 11'b000_0000_0001,
        PH_CMD  = 11'b000_0000_0010,
        PH_P0   = 11'b000_0000_0100,
        PH_P1   = 11'b000_0000_1000,
        PH_P2   = 11'b000_0001_0000,
        PH_P3   = 11'b000_0010_0000,
        PH_P4   = 11'b000_0100_0000,
        PH_P5   = 11'b000_1000_0000,
        PH_P6   = 11'b001_0000_0000,
        PH_P7   = 11'b010_0000_0000,
        PH_CRC  = 11'b100_0000_0000
    } phase_t;

    // One result beat
    typedef struct packed {
        logic        crc_ok;
        logic [7:0]  command_id;
        logic [31:0] slider_bits;
        logic [31:0] position_bits;
        logic [7:0]  computed_crc;
        logic [7:0]  received_crc;
        logic [31:0] pass_count;
        logic [31:0] fail_count;
    } result_t;

    // CRC-8/MAXIM, LSB first, one byte
    function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        c = crc ^ data;
        for (int b = 0; b < 8; b++)
        begin
            if (c[0])
                c = (c >> 1) ^ CRC_POLY_REFL;
            else
                c = c >> 1;
        end
        return c;
    endfunction

endpackage

// ===== rtl/core/fpr_crc8_if.sv =====
`timescale 1ns / 1ps
// Valid/ready channel interfaces for received bytes and frame results.

interface fpr_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

interface fpr_res_if;
    logic        valid;
    logic        ready;
    logic        crc_ok;
    logic [7:0]  command_id;
    logic [31:0] slider_bits;
    logic [31:0] position_bits;
    logic [7:0]  computed_crc;
    logic [7:0]  received_crc;
    logic [31:0] pass_count;
    logic [31:0] fail_count;

    modport source (
        output valid, output crc_ok, output command_id, output slider_bits,
        output position_bits, output computed_crc, output received_crc,
        output pass_count, output fail_count, input ready
    );
    modport sink (
        input valid, input crc_ok, input command_id, input slider_bits,
        input position_bits, input computed_crc, input received_crc,
        input pass_count, input fail_count, output ready
    );
endinterface

// ===== rtl/core/framed_packet_receiver_crc8.sv =====
`timescale 1ns / 1ps
// Framed packet receiver: header hunt, byte-wise CRC-8/MAXIM, frame check and counters.
// The result beat is registered and is valid in the cycle after the CRC byte is accepted.
// Throughput: one received byte per cycle, but for the stall below; the byte FSM and CRC update are combinational.
// The input stalls only when a CRC byte arrives while the previous result is still unread.
// Reset (rst_n low, asynchronous): phase to header hunt, CRC, holds and counters to zero,
// header register to 0xA5, no result pending.
module framed_packet_receiver_crc8 (
    input  logic                                  clk,
    input  logic                                  rst_n,
    fpr_rx_if.sink                                rx_chan,
    fpr_res_if.source                             res_chan,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [fpr_crc8_pkg::CFG_ADDR_W-1:0]   paddr,
    input  logic [31:0]                           pwdata,
    output logic [31:0]                           prdata,
    output logic                                  pready
);

    logic [7:0]            header_reg;
    fpr_crc8_pkg::phase_t  phase_reg, phase_next;
    logic [7:0]            crc_reg, crc_next;
    logic [7:0]            cmd_reg, cmd_next;
    logic [31:0]           slider_asm_reg, slider_asm_next;
    logic [31:0]           pos_asm_reg, pos_asm_next;
    logic [31:0]           slider_acc_reg, slider_acc_next;
    logic [31:0]           pos_acc_reg, pos_acc_next;
    logic [31:0]           good_reg, good_next;
    logic [31:0]           bad_reg, bad_next;
    logic                  res_valid_reg, res_valid_next;
    fpr_crc8_pkg::result_t result_reg, result_next;

    logic       rx_fire;
    logic       res_fire;
    logic       cfg_wr;
    logic       crc_ok;
    logic [7:0] rx_b;
    logic [7:0] crc_upd;

    // Handshakes; only a CRC byte needs room in the result register
    assign res_fire = res_chan.valid && res_chan.ready;
    assign rx_chan.ready = (phase_reg != fpr_crc8_pkg::PH_CRC) || !res_valid_reg
                           || res_chan.ready;
    assign rx_fire = rx_chan.valid && rx_chan.ready;
    assign rx_b    = rx_chan.rx_byte;
    assign crc_upd = fpr_crc8_pkg::crc8_update(crc_reg, rx_b);
    assign crc_ok  = (crc_reg == rx_b);

    // APB register port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready
                    && (paddr[2] == fpr_crc8_pkg::REG_HEADER);
    assign prdata = (paddr[2] == fpr_crc8_pkg::REG_HEADER) ? {24'd0, header_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            header_reg <= fpr_crc8_pkg::HEADER_RESET;
        else if (cfg_wr)
            header_reg <= pwdata[7:0];
    end

    // Frame FSM, byte assembly and check
    always_comb
    begin
        phase_next      = phase_reg;
        crc_next        = crc_reg;
        cmd_next        = cmd_reg;
        slider_asm_next = slider_asm_reg;
        pos_asm_next    = pos_asm_reg;
        slider_acc_next = slider_acc_reg;
        pos_acc_next    = pos_acc_reg;
        good_next       = good_reg;
        bad_next        = bad_reg;
        if (rx_fire)
        begin
            case (phase_reg)
                fpr_crc8_pkg::PH_WAIT:
                begin
                    if (rx_b == header_reg)
                    begin
                        phase_next = fpr_crc8_pkg::PH_CMD;
                        crc_next   = 8'd0;
                    end
                end
                fpr_crc8_pkg::PH_CMD:
                begin
                    cmd_next   = rx_b;
                    crc_next   = crc_upd;
                    phase_next = fpr_crc8_pkg::PH_P0;
                end
                fpr_crc8_pkg::PH_P0:
                begin
                    slider_asm_next[7:0] = rx_b;
                    crc_next   = crc_upd;
                    phase_next = fpr_crc8_pkg::PH_P1;
                end
                fpr_crc8_pkg::PH_P1:
                begin
                    slider_asm_next[15:8] = rx_b;
                    crc_next   = crc_upd;
                    phase_next = fpr_crc8_pkg::PH_P2;
                end
                fpr_crc8_pkg::PH_P2:
                begin
                    slider_asm_next[23:16] = rx_b;
                    crc_next   = crc_upd;
                    phase_next = fpr_crc8_pkg::PH_P3;
                end
                fpr_crc8_pkg::PH_P3:
                begin
                    slider_asm_next[31:24] = rx_b;
                    crc_next   = crc_upd;
                    phase_next = fpr_crc8_pkg::PH_P4;
                end
                fpr_crc8_pkg::PH_P4:
                begin
                    pos_asm_next[7:0] = rx_b;
                    crc_next   = crc_upd;
                    phase_next = fpr_crc8_pkg::PH_P5;
                end
                fpr_crc8_pkg::PH_P5:
                begin
                    pos_asm_next[15:8] = rx_b;
                    crc_next   = crc_upd;
                    phase_next = fpr_crc8_pkg::PH_P6;
                end
                fpr_crc8_pkg::PH_P6:
                begin
                    pos_asm_next[23:16] = rx_b;
                    crc_next   = crc_upd;
                    phase_next = fpr_crc8_pkg::PH_P7;
                end
                fpr_crc8_pkg::PH_P7:
                begin
                    pos_asm_next[31:24] = rx_b;
                    crc_next   = crc_upd;
                    phase_next = fpr_crc8_pkg::PH_CRC;
                end
                fpr_crc8_pkg::PH_CRC:
                begin
                    if (crc_ok)
                    begin
                        slider_acc_next = slider_asm_reg;
                        pos_acc_next    = pos_asm_reg;
                        good_next       = good_reg + 32'd1;
                    end
                    else
                        bad_next = bad_reg + 32'd1;
                    phase_next = fpr_crc8_pkg::PH_WAIT;
                end
                default:
                    phase_next = fpr_crc8_pkg::PH_WAIT;
            endcase
        end
    end

    // Result register
    always_comb
    begin
        result_next    = result_reg;
        res_valid_next = res_valid_reg;
        if (res_fire)
            res_valid_next = 1'b0;
        if (rx_fire && (phase_reg == fpr_crc8_pkg::PH_CRC))
        begin
            res_valid_next            = 1'b1;
            result_next.crc_ok        = crc_ok;
            result_next.command_id    = cmd_reg;
            result_next.slider_bits   = slider_acc_next;
            result_next.position_bits = pos_acc_next;
            result_next.computed_crc  = crc_reg;
            result_next.received_crc  = rx_b;
            result_next.pass_count    = good_next;
            result_next.fail_count    = bad_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= fpr_crc8_pkg::PH_WAIT;
            crc_reg        <= 8'd0;
            cmd_reg        <= 8'd0;
            slider_asm_reg <= 32'd0;
            pos_asm_reg    <= 32'd0;
            slider_acc_reg <= 32'd0;
            pos_acc_reg    <= 32'd0;
            good_reg       <= 32'd0;
            bad_reg        <= 32'd0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            phase_reg      <= phase_next;
            crc_reg        <= crc_next;
            cmd_reg        <= cmd_next;
            slider_asm_reg <= slider_asm_next;
            pos_asm_reg    <= pos_asm_next;
            slider_acc_reg <= slider_acc_next;
            pos_acc_reg    <= pos_acc_next;
            good_reg       <= good_next;
            bad_reg        <= bad_next;
            res_valid_reg  <= res_valid_next;
        end
    end

    // Payload register, no reset
    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign res_chan.valid         = res_valid_reg;
    assign res_chan.crc_ok        = result_reg.crc_ok;
    assign res_chan.command_id    = result_reg.command_id;
    assign res_chan.slider_bits   = result_reg.slider_bits;
    assign res_chan.position_bits = result_reg.position_bits;
    assign res_chan.computed_crc  = result_reg.computed_crc;
    assign res_chan.received_crc  = result_reg.received_crc;
    assign res_chan.pass_count    = result_reg.pass_count;
    assign res_chan.fail_count    = result_reg.fail_count;

    // Checks
    a_stall_only_on_crc: assert property (@(posedge clk) disable iff (!rst_n)
        !rx_chan.ready |-> (phase_reg == fpr_crc8_pkg::PH_CRC) && res_valid_reg
                           && !res_chan.ready)
        else $error("input stalled outside a blocked CRC byte");

    a_crc_byte_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        (rx_fire && (phase_reg == fpr_crc8_pkg::PH_CRC)) |=> res_valid_reg)
        else $error("CRC byte did not load a result");

    a_one_count_per_frame: assert property (@(posedge clk) disable iff (!rst_n)
        (rx_fire && (phase_reg == fpr_crc8_pkg::PH_CRC))
        |=> ((good_reg + bad_reg) == ($past(good_reg) + $past(bad_reg) + 32'd1)))
        else $error("frame counters did not advance by one");

    a_ok_matches_crcs: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg |-> (result_reg.crc_ok
                           == (result_reg.computed_crc == result_reg.received_crc)))
        else $error("crc_ok disagrees with CRC fields");

endmodule

// ===== bench/framed_packet_receiver_crc8_tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for the framed packet receiver: directed table, random frames, APB writes.
module framed_packet_receiver_crc8_tb;

    localparam int          SETTLE_CYCLES   = 6;
    localparam int          CYCLE_LIMIT     = 300000;
    localparam int          ITEMS_PER_PHASE = 290;
    localparam int          NUM_PHASES      = 6;
    localparam int          MAX_REPORTS     = 10;
    localparam logic [fpr_crc8_pkg::CFG_ADDR_W-1:0] ADDR_HEADER =
        fpr_crc8_pkg::CFG_ADDR_W'(4 * int'(fpr_crc8_pkg::REG_HEADER));
    localparam logic [fpr_crc8_pkg::CFG_ADDR_W-1:0] ADDR_UNMAPPED =
        fpr_crc8_pkg::CFG_ADDR_W'(4 * (int'(fpr_crc8_pkg::REG_HEADER) + 1));

    // Kinds of rows in the directed table
    typedef enum logic [2:0] {
        ROW_RAW,
        ROW_HDR,
        ROW_DATA,
        ROW_CRC_GOOD,
        ROW_CRC_BAD,
        ROW_CFG
    } row_kind_t;

    typedef struct packed {
        row_kind_t                             kind;
        logic [7:0]                            val;
        logic [3:0]                            reps;
        logic [fpr_crc8_pkg::CFG_ADDR_W-1:0]   addr;
        logic                                  typed;
        fpr_crc8_pkg::result_t                 res;
    } stim_row_t;

    localparam fpr_crc8_pkg::result_t ZERO_FRAME_RES =
        fpr_crc8_pkg::result_t'{1'b1, 8'h00, 32'h0, 32'h0, 8'h00, 8'h00, 32'd1, 32'd0};
    localparam fpr_crc8_pkg::result_t NO_RESULT = '0;

    // Directed frames: an all-zero frame right after reset, then an all-ones frame with the
    // header value inside it, a header write and an unmapped write mid-frame, and a bad CRC.
    stim_row_t directed_rows [13] = '{
        '{ROW_RAW,      8'h3C, 4'd1, ADDR_HEADER,   1'b0, NO_RESULT},
        '{ROW_RAW,      8'h00, 4'd1, ADDR_HEADER,   1'b0, NO_RESULT},
        '{ROW_HDR,      8'h00, 4'd1, ADDR_HEADER,   1'b0, NO_RESULT},
        '{ROW_DATA,     8'h00, 4'd9, ADDR_HEADER,   1'b0, NO_RESULT},
        '{ROW_CRC_GOOD, 8'h00, 4'd1, ADDR_HEADER,   1'b1, ZERO_FRAME_RES},
        '{ROW_HDR,      8'h00, 4'd1, ADDR_HEADER,   1'b0, NO_RESULT},
        '{ROW_DATA,     8'hFF, 4'd1, ADDR_HEADER,   1'b0, NO_RESULT},
        '{ROW_DATA,     8'hA5, 4'd1, ADDR_HEADER,   1'b0, NO_RESULT},
        '{ROW_DATA,     8'hFF, 4'd2, ADDR_HEADER,   1'b0, NO_RESULT},
        '{ROW_CFG,      8'h00, 4'd1, ADDR_HEADER,   1'b0, NO_RESULT},
        '{ROW_CFG,      8'hFF, 4'd1, ADDR_UNMAPPED, 1'b0, NO_RESULT},
        '{ROW_DATA,     8'hFF, 4'd5, ADDR_HEADER,   1'b0, NO_RESULT},
        '{ROW_CRC_BAD,  8'h00, 4'd1, ADDR_HEADER,   1'b0, NO_RESULT}
    };

    // Idle settings per random phase
    int unsigned phase_gap_pct   [NUM_PHASES] = '{0, 73, 0, 37, 0, 37};
    int unsigned phase_stall_pct [NUM_PHASES] = '{0, 0, 73, 37, 0, 37};

    logic                                  clk = 1'b0;
    logic                                  rst_n;
    logic                                  psel;
    logic                                  penable;
    logic                                  pwrite;
    logic [fpr_crc8_pkg::CFG_ADDR_W-1:0]   paddr;
    logic [31:0]                           pwdata;
    logic [31:0]                           prdata;
    logic                                  pready;

    fpr_rx_if  rx ();
    fpr_res_if res ();

    framed_packet_receiver_crc8 dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .rx_chan  (rx),
        .res_chan (res),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // Predicted receiver state
    logic [7:0]           frame_marker = fpr_crc8_pkg::HEADER_RESET;
    fpr_crc8_pkg::phase_t frame_phase  = fpr_crc8_pkg::PH_WAIT;
    int                   pay_slot     = 0;
    logic [7:0]           crc_acc      = 8'h00;
    logic [7:0]           cmd_latch    = 8'h00;
    logic [31:0]          slider_acc   = 32'h0;
    logic [31:0]          posn_acc     = 32'h0;
    logic [31:0]          slider_good  = 32'h0;
    logic [31:0]          posn_good    = 32'h0;
    logic [31:0]          good_total   = 32'h0;
    logic [31:0]          bad_total    = 32'h0;

    fpr_crc8_pkg::result_t expected_results [$];

    // Stimulus-side bookkeeping
    logic [7:0]            tx_crc;
    logic                  typed_on;
    fpr_crc8_pkg::result_t typed_res;
    int unsigned           send_gap_pct;
    int unsigned           recv_stall_pct;
    int                    errors;
    int                    cycle_count = 0;

    always #5 clk = ~clk;

    // CRC-8/MAXIM, one bit at a time, LSB first
    function automatic logic [7:0] crc8_bitwise(input logic [7:0] crc, input logic [7:0] d);
        logic [7:0] c;
        logic       fb;
        c = crc;
        for (int i = 0; i < 8; i++)
        begin
            fb = c[0] ^ d[i];
            c  = c >> 1;
            if (fb)
                c = c ^ fpr_crc8_pkg::CRC_POLY_REFL;
        end
        return c;
    endfunction

    task automatic flag_error(input string msg);
        errors++;
        if (errors <= MAX_REPORTS)
            $display("[%0t] MISMATCH %s", $realtime, msg);
    endtask

    task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
        if (got !== want)
            flag_error($sformatf("%s: expected %h, got %h", name, want, got));
    endtask

    // Advance the predicted receiver by one accepted byte
    task automatic frame_step(input logic [7:0] b, output bit emitted,
                              output fpr_crc8_pkg::result_t r);
        emitted = 1'b0;
        r       = '0;
        case (frame_phase)
            fpr_crc8_pkg::PH_WAIT:
            begin
                if (b == frame_marker)
                begin
                    frame_phase = fpr_crc8_pkg::PH_CMD;
                    crc_acc     = 8'h00;
                end
            end
            fpr_crc8_pkg::PH_CMD:
            begin
                cmd_latch   = b;
                crc_acc     = crc8_bitwise(crc_acc, b);
                pay_slot    = 0;
                frame_phase = fpr_crc8_pkg::PH_P0;
            end
            fpr_crc8_pkg::PH_CRC:
            begin
                if (crc_acc == b)
                begin
                    slider_good = slider_acc;
                    posn_good   = posn_acc;
                    good_total  = good_total + 32'd1;
                end
                else
                    bad_total = bad_total + 32'd1;
                r.crc_ok        = (crc_acc == b);
                r.command_id    = cmd_latch;
                r.slider_bits   = slider_good;
                r.position_bits = posn_good;
                r.computed_crc  = crc_acc;
                r.received_crc  = b;
                r.pass_count    = good_total;
                r.fail_count    = bad_total;
                emitted         = 1'b1;
                frame_phase     = fpr_crc8_pkg::PH_WAIT;
            end
            default:
            begin
                // payload bytes, little-endian, slider word first
                if (pay_slot < 4)
                    slider_acc[8*pay_slot +: 8] = b;
                else
                    posn_acc[8*(pay_slot-4) +: 8] = b;
                crc_acc     = crc8_bitwise(crc_acc, b);
                pay_slot    = pay_slot + 1;
                frame_phase = fpr_crc8_pkg::phase_t'(frame_phase << 1);
            end
        endcase
    endtask

    // Offer one byte, with a random gap ahead of it, and hold it until accepted
    task automatic send_byte(input logic [7:0] b, input bit use_typed,
                             input fpr_crc8_pkg::result_t typed);
        while ($urandom_range(99) < send_gap_pct)
        begin
            rx.valid <= 1'b0;
            @(posedge clk);
        end
        rx.valid   <= 1'b1;
        rx.rx_byte <= b;
        typed_on   <= use_typed;
        typed_res  <= typed;
        do
            @(posedge clk);
        while (rx.ready !== 1'b1);
    endtask

    // Hold off the sender until every predicted result has come out
    task automatic drain_results();
        rx.valid <= 1'b0;
        @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // APB write while idle, then read the header register back
    task automatic cfg_write(input logic [fpr_crc8_pkg::CFG_ADDR_W-1:0] addr,
                             input logic [31:0] data);
        drain_results();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (pready !== 1'b1);
        psel    <= 1'b0;
        penable <= 1'b0;
        if ((int'(addr) >> 2) == int'(fpr_crc8_pkg::REG_HEADER))
            frame_marker = data[7:0];
        @(posedge clk);
        psel    <= 1'b1;
        pwrite  <= 1'b0;
        paddr   <= ADDR_HEADER;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (pready !== 1'b1);
        check_field("header readback", {24'h0, frame_marker}, {24'h0, prdata[7:0]});
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Input monitor: every accepted byte steps the predictor
    always @(posedge clk)
    begin : rx_monitor
        bit                    emitted;
        fpr_crc8_pkg::result_t r;
        if (rst_n === 1'b1 && rx.valid === 1'b1 && rx.ready === 1'b1)
        begin
            frame_step(rx.rx_byte, emitted, r);
            if (emitted)
                expected_results.push_back(typed_on ? typed_res : r);
        end
    end

    // Result monitor: compare each accepted beat with the oldest prediction
    always @(posedge clk)
    begin : res_monitor
        fpr_crc8_pkg::result_t want;
        if (rst_n === 1'b1 && res.valid === 1'b1 && res.ready === 1'b1)
        begin
            if (expected_results.size() == 0)
                flag_error("result beat with nothing expected");
            else
            begin
                want = expected_results.pop_front();
                check_field("crc_ok", {31'h0, want.crc_ok}, {31'h0, res.crc_ok});
                check_field("command_id", {24'h0, want.command_id}, {24'h0, res.command_id});
                check_field("slider_bits", want.slider_bits, res.slider_bits);
                check_field("position_bits", want.position_bits, res.position_bits);
                check_field("computed_crc", {24'h0, want.computed_crc},
                            {24'h0, res.computed_crc});
                check_field("received_crc", {24'h0, want.received_crc},
                            {24'h0, res.received_crc});
                check_field("pass_count", want.pass_count, res.pass_count);
                check_field("fail_count", want.fail_count, res.fail_count);
            end
        end
    end

    // Result-side backpressure
    always @(posedge clk)
        res.ready <= ($urandom_range(99) >= recv_stall_pct);

    // Run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Main stimulus
    initial
    begin
        stim_row_t   row;
        int          phase_items;
        int          burst;
        logic [7:0]  b;

        errors         = 0;
        send_gap_pct   = 0;
        recv_stall_pct = 0;
        tx_crc         = 8'h00;
        typed_on       = 1'b0;
        typed_res      = '0;
        rx.valid       = 1'b0;
        rx.rx_byte     = 8'h00;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = 32'h0;
        rst_n          = 1'b0;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table
        foreach (directed_rows[i])
        begin
            row = directed_rows[i];
            case (row.kind)
                ROW_RAW:
                    send_byte(row.val, 1'b0, NO_RESULT);
                ROW_HDR:
                begin
                    tx_crc = 8'h00;
                    send_byte(frame_marker, 1'b0, NO_RESULT);
                end
                ROW_DATA:
                begin
                    repeat (row.reps)
                    begin
                        tx_crc = crc8_bitwise(tx_crc, row.val);
                        send_byte(row.val, 1'b0, NO_RESULT);
                    end
                end
                ROW_CRC_GOOD:
                    send_byte(tx_crc, row.typed, row.res);
                ROW_CRC_BAD:
                    send_byte(~tx_crc, row.typed, row.res);
                ROW_CFG:
                    cfg_write(row.addr, {24'h0, row.val});
                default:
                    flag_error("unknown table row");
            endcase
        end

        // Random phases: mostly well-formed frames, some noise and unaligned bursts
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            case (p)
                0: cfg_write(ADDR_HEADER, 32'h00);
                1: cfg_write(ADDR_HEADER, 32'hFF);
                3: cfg_write(ADDR_HEADER, {24'h0, fpr_crc8_pkg::HEADER_RESET});
                default: cfg_write(ADDR_HEADER, $urandom);
            endcase
            send_gap_pct   = phase_gap_pct[p];
            recv_stall_pct = phase_stall_pct[p];
            phase_items    = 0;
            while (phase_items < ITEMS_PER_PHASE)
            begin
                // non-header bytes between frames, ignored unless a burst has left a frame open
                if ($urandom_range(99) < 30)
                begin
                    repeat ($urandom_range(3, 1))
                    begin
                        do
                            b = 8'($urandom);
                        while (b == frame_marker);
                        send_byte(b, 1'b0, NO_RESULT);
                        phase_items++;
                    end
                end
                if ($urandom_range(99) < 5)
                begin
                    // any byte at all, may open a frame at an odd point
                    burst = $urandom_range(12, 1);
                    repeat (burst) send_byte(8'($urandom), 1'b0, NO_RESULT);
                    phase_items += burst;
                end
                else
                begin
                    tx_crc = 8'h00;
                    send_byte(frame_marker, 1'b0, NO_RESULT);
                    repeat (9)
                    begin
                        case ($urandom_range(9))
                            0: b = frame_marker;
                            1: b = 8'h00;
                            2: b = 8'hFF;
                            default: b = 8'($urandom);
                        endcase
                        tx_crc = crc8_bitwise(tx_crc, b);
                        send_byte(b, 1'b0, NO_RESULT);
                    end
                    if ($urandom_range(99) < 70)
                        send_byte(tx_crc, 1'b0, NO_RESULT);
                    else
                        send_byte(tx_crc ^ 8'($urandom_range(255, 1)), 1'b0, NO_RESULT);
                    phase_items += 11;
                end
            end
        end

        drain_results();
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
